// ===== hw/rtl/rv32i_integer_alu_execute_defines.svh =====
// Assertion macros for the RV32I ALU execute block.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef RV32I_INTEGER_ALU_EXECUTE_DEFINES_SVH
`define RV32I_INTEGER_ALU_EXECUTE_DEFINES_SVH

`ifndef SYNTHESIS
// check with reset masking
`define RVALU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
// check that also covers reset cycles
`define RVALU_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define RVALU_ASSERT(lbl, clk, rstn, prop, msg)
`define RVALU_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/rvalu_pkg.sv =====
// Shared types and encodings for the RV32I ALU execute block.
// No dependencies.
package rvalu_pkg;

    typedef enum logic [1:0] {
        ACT_EXEC  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ILLEGAL     = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef struct packed {
        status_t     status;
        logic [31:0] result;
    } alu_res_t;

endpackage

// ===== hw/rtl/rvalu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rvalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rvalu_alu.sv =====
// RV32I OP / OP-IMM decoder and ALU, purely combinational.
// Depends on rvalu_pkg.
module rvalu_alu
    import rvalu_pkg::*;
#(
    parameter int REGISTER_COUNT = 32
) (
    input  logic [31:0] instruction,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output alu_res_t    res
);

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [31:0] imm;
    logic        is_op;
    logic        rd_ok, rs1_ok, rs2_ok;
    logic [31:0] b;
    logic [4:0]  shamt;
    logic [31:0] sum, diff, sll_v, srl_v, sra_v;
    logic        slt_v, sltu_v;

    assign opc = instruction[6:0];
    assign rd  = instruction[11:7];
    assign f3  = instruction[14:12];
    assign rs1 = instruction[19:15];
    assign rs2 = instruction[24:20];
    assign f7  = instruction[31:25];
    assign imm = {{20{instruction[31]}}, instruction[31:20]};

    assign rd_ok  = int'(rd)  < REGISTER_COUNT;
    assign rs1_ok = int'(rs1) < REGISTER_COUNT;
    assign rs2_ok = int'(rs2) < REGISTER_COUNT;

    // immediate shifts take the amount from the rs2 field
    assign is_op = (opc == OPC_OP);
    assign b     = is_op ? op_b : imm;
    assign shamt = is_op ? op_b[4:0] : rs2;

    assign sum    = op_a + b;
    assign diff   = op_a - b;
    assign sll_v  = op_a << shamt;
    assign srl_v  = op_a >> shamt;
    assign sra_v  = 32'($signed(op_a) >>> shamt);
    assign slt_v  = $signed(op_a) < $signed(b);
    assign sltu_v = op_a < b;

    always_comb begin
        res.status = ST_OK;
        res.result = '0;
        case (opc)
            OPC_OP: begin
                if (!(rd_ok && rs1_ok && rs2_ok)) begin
                    res.status = ST_ILLEGAL;
                end else if (f7 == F7_ALT) begin
                    case (f3)
                        F3_ADD:  res.result = diff;
                        F3_SR:   res.result = sra_v;
                        default: res.status = ST_ILLEGAL;
                    endcase
                end else if (f7 != F7_BASE) begin
                    res.status = ST_ILLEGAL;
                end else begin
                    case (f3)
                        F3_ADD:  res.result = sum;
                        F3_SLL:  res.result = sll_v;
                        F3_SLT:  res.result = {31'd0, slt_v};
                        F3_SLTU: res.result = {31'd0, sltu_v};
                        F3_XOR:  res.result = op_a ^ b;
                        F3_SR:   res.result = srl_v;
                        F3_OR:   res.result = op_a | b;
                        default: res.result = op_a & b;
                    endcase
                end
            end
            OPC_OPIMM: begin
                if (!(rd_ok && rs1_ok)) begin
                    res.status = ST_ILLEGAL;
                end else begin
                    case (f3)
                        F3_ADD:  res.result = sum;
                        F3_SLL: begin
                            if (f7 == F7_BASE) res.result = sll_v;
                            else               res.status = ST_ILLEGAL;
                        end
                        F3_SLT:  res.result = {31'd0, slt_v};
                        F3_SLTU: res.result = {31'd0, sltu_v};
                        F3_XOR:  res.result = op_a ^ b;
                        F3_SR: begin
                            if (f7 == F7_BASE)     res.result = srl_v;
                            else if (f7 == F7_ALT) res.result = sra_v;
                            else                   res.status = ST_ILLEGAL;
                        end
                        F3_OR:   res.result = op_a | b;
                        default: res.result = op_a & b;
                    endcase
                end
            end
            OPC_LOAD, OPC_JAL, OPC_JALR, OPC_SYSTEM: begin
                res.status = ST_UNSUPPORTED;
            end
            default: begin
                res.status = ST_ILLEGAL;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rv32i_integer_alu_execute.sv =====
// RV32I integer ALU execute stage with register file RAM and program counter.
// Depends on rvalu_pkg, rvalu_ram, rvalu_alu and the assertion macro header.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | instruction, reg_index, write_value          | action
//  m_      | out | next_pc, dest_index, dest_value,             | status
//          |     | dest_written, read_value                     |
//
// One item per cycle sustained while m_tready is high; the input transfer loads the execute stage registers,
// and m_tvalid is registered when execute advances. Register file sits in two RAM copies (rs1 and rs2 ports),
// read on the input transfer; ALU runs the next cycle and write-back when execute advances, with a one-entry
// forward of the last write. Reset clears the pc and every per-entry valid bit at once; no clearing pass.
// While m_tready is low with a result held, an item in execute holds and s_tready drops.
`include "rv32i_integer_alu_execute_defines.svh"

module rv32i_integer_alu_execute
    import rvalu_pkg::*;
#(
    parameter int REGISTER_COUNT = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // instruction[31:0], reg_index[36:32], write_value[68:37]
    input  logic [1:0]   s_tuser,   // action[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[31:0], dest_index[36:32], dest_value[68:37], dest_written[69],
    // read_value[101:70]
    output logic [103:0] m_tdata,
    output logic [1:0]   m_tuser    // status[1:0]
);

    localparam int AW = $clog2(REGISTER_COUNT);

    // input unpack
    logic [31:0] in_instr;
    logic [4:0]  in_idx;
    logic [31:0] in_wval;
    logic [4:0]  rd_idx_a, rd_idx_b;
    logic        s_accept;

    assign in_instr = s_tdata[31:0];
    assign in_idx   = s_tdata[36:32];
    assign in_wval  = s_tdata[68:37];
    assign rd_idx_a = (s_tuser == ACT_READ) ? in_idx : in_instr[19:15];
    assign rd_idx_b = in_instr[24:20];

    // execute stage registers
    logic                      s1_valid_reg;
    logic [1:0]                s1_action_reg;
    logic [31:0]               s1_instr_reg;
    logic [4:0]                s1_idx_reg;
    logic [31:0]               s1_wval_reg;
    logic [4:0]                s1_idx_a_reg, s1_idx_b_reg;
    logic                      s1_a_valid_reg, s1_b_valid_reg;
    logic [REGISTER_COUNT-1:0] valid_reg;
    logic [31:0]               pc_reg, pc_next;
    logic                      byp_valid_reg;
    logic [4:0]                byp_idx_reg;
    logic [31:0]               byp_data_reg;

    logic                      m_tvalid_reg;
    logic [103:0]              m_tdata_reg, m_tdata_next;
    logic [1:0]                m_tuser_reg;
    status_t                   status_next;

    logic        s1_adv;
    logic        s1_stall;
    logic [31:0] ram_a_q, ram_b_q;
    logic [31:0] op_a, op_b;
    alu_res_t    alu_res;

    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic [31:0] read_value;
    logic        wr_en;
    logic [4:0]  wr_idx;

    assign s1_adv   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s1_stall = s1_valid_reg && !s1_adv;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    rvalu_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_ram_a (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_idx[AW-1:0]),
        .wdata (dest_value),
        .re    (s_accept),
        .raddr (rd_idx_a[AW-1:0]),
        .rdata (ram_a_q)
    );

    rvalu_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_ram_b (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_idx[AW-1:0]),
        .wdata (dest_value),
        .re    (s_accept),
        .raddr (rd_idx_b[AW-1:0]),
        .rdata (ram_b_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // entries never written (x0, out-of-range, or since reset) read as zero
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_action_reg  <= s_tuser;
            s1_instr_reg   <= in_instr;
            s1_idx_reg     <= in_idx;
            s1_wval_reg    <= in_wval;
            s1_idx_a_reg   <= rd_idx_a;
            s1_idx_b_reg   <= rd_idx_b;
            s1_a_valid_reg <= (int'(rd_idx_a) < REGISTER_COUNT) && valid_reg[rd_idx_a[AW-1:0]];
            s1_b_valid_reg <= (int'(rd_idx_b) < REGISTER_COUNT) && valid_reg[rd_idx_b[AW-1:0]];
        end
    end

    // forward covers the write that lands on the same edge as the RAM read
    assign op_a = (byp_valid_reg && byp_idx_reg == s1_idx_a_reg) ? byp_data_reg :
                  (s1_a_valid_reg ? ram_a_q : '0);
    assign op_b = (byp_valid_reg && byp_idx_reg == s1_idx_b_reg) ? byp_data_reg :
                  (s1_b_valid_reg ? ram_b_q : '0);

    rvalu_alu #(.REGISTER_COUNT(REGISTER_COUNT)) u_alu (
        .instruction (s1_instr_reg),
        .op_a        (op_a),
        .op_b        (op_b),
        .res         (alu_res)
    );

    always_comb begin
        dest_index   = '0;
        dest_value   = '0;
        dest_written = 1'b0;
        read_value   = '0;
        status_next  = ST_OK;
        pc_next      = pc_reg;
        case (s1_action_reg)
            ACT_EXEC: begin
                status_next = alu_res.status;
                if (alu_res.status == ST_OK) begin
                    dest_index   = s1_instr_reg[11:7];
                    dest_value   = alu_res.result;
                    dest_written = (s1_instr_reg[11:7] != '0);
                    pc_next      = pc_reg + PC_STEP;
                end
            end
            ACT_READ: begin
                read_value = op_a;
            end
            ACT_WRITE: begin
                dest_index   = s1_idx_reg;
                dest_value   = s1_wval_reg;
                dest_written = (s1_idx_reg != '0) && (int'(s1_idx_reg) < REGISTER_COUNT);
            end
            default: begin
                status_next = ST_ILLEGAL;
            end
        endcase
    end

    assign wr_en  = s1_adv && dest_written;
    assign wr_idx = dest_index;

    assign m_tdata_next = {2'b00, read_value, dest_written, dest_value, dest_index, pc_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            valid_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            pc_reg        <= pc_next;
            byp_valid_reg <= wr_en;
            if (wr_en) begin
                valid_reg[wr_idx[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            byp_idx_reg  <= wr_idx;
            byp_data_reg <= dest_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `RVALU_ASSERT(a_no_x0_write, aclk, aresetn, wr_en |-> (wr_idx != '0), "write to x0")
    `RVALU_ASSERT(a_stall_no_read, aclk, aresetn, s1_stall |-> !s_accept, "accept in stall")
    `RVALU_ASSERT(a_pc_hold, aclk, aresetn, !s1_adv |=> $stable(pc_reg), "pc moved")
    `RVALU_ASSERT_NR(a_reset_clear, aclk, !aresetn |=> (valid_reg == '0 && !m_tvalid_reg), "no reset")

endmodule
